### rtl/mdf_pkg.sv
package mdf_pkg;

  localparam int MAX_TOKEN_BYTES = 8;
  localparam int TLEN_W          = 4;
  localparam int HIST_IDX_W      = $clog2(MAX_TOKEN_BYTES);
  localparam int LEN_W           = 32;
  localparam int CFG_DATA_W      = 64;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CFG_FRAMING_MODE = 2'd0,
    CFG_MAX_LEN      = 2'd1,
    CFG_TOKEN_LEN    = 2'd2,
    CFG_TOKEN_BYTES  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_LEN1  = 2'd0,
    MODE_LEN2  = 2'd1,
    MODE_LEN4  = 2'd2,
    MODE_TOKEN = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_ERROR  = 3'b100
  } phase_t;

  localparam mode_t                   RST_MODE        = MODE_LEN4;
  localparam logic [LEN_W-1:0]        RST_MAX_LEN     = 32'd102400;
  localparam logic [TLEN_W-1:0]       RST_TOKEN_LEN   = 4'd2;
  localparam logic [CFG_DATA_W-1:0]   RST_TOKEN_BYTES = 64'h0000_0000_0000_0D0A;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_message;
    logic       framing_error;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t data;
  } q_wr_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } q_head_t;

endpackage

### rtl/mdf_if.sv
interface mdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface mdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_of_message;
  logic       framing_error;

  modport source (output valid, output payload_byte, output last_of_message,
                  output framing_error, input ready);
  modport sink   (input valid, input payload_byte, input last_of_message,
                  input framing_error, output ready);
endinterface

### rtl/mdf_front.sv
module mdf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  mdf_pkg::cfg_idx_t                cfg_index,
  input  logic [mdf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_fire,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_restart,
  output mdf_pkg::q_wr_t                   q_wr
);
  import mdf_pkg::*;

  mode_t                   mode_r;
  logic [LEN_W-1:0]        max_len_r;
  logic [TLEN_W-1:0]       tok_len_r;
  logic [CFG_DATA_W-1:0]   tok_bytes_r;

  phase_t                  phase_r, phase_nxt;
  logic [LEN_W-1:0]        accum_r, accum_nxt;
  logic [2:0]              hdr_cnt_r, hdr_cnt_nxt;
  logic [LEN_W-1:0]        left_r, left_nxt;
  logic [TLEN_W-1:0]       fill_r, fill_nxt;
  logic [7:0]              hist_r [MAX_TOKEN_BYTES];

  phase_t                  cur_phase;
  logic [LEN_W-1:0]        cur_accum;
  logic [2:0]              cur_hc;
  logic [LEN_W-1:0]        cur_left;
  logic [TLEN_W-1:0]       cur_fill;

  logic [TLEN_W-1:0]       t_len;
  logic [2:0]              h_size;
  logic [7:0]              tok_arr [MAX_TOKEN_BYTES];
  logic [TLEN_W-1:0]       fill_a, fill2;
  logic                    match, has_old, emit_ok;
  logic [7:0]              oldest;
  logic [LEN_W-1:0]        acc_sh;
  logic [2:0]              hc1;
  logic                    cfg_clear;

  always_comb begin
    for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
      tok_arr[k] = tok_bytes_r[8*k +: 8];
    end
  end

  always_comb begin
    if (tok_len_r == '0) begin
      t_len = TLEN_W'(1);
    end else if (tok_len_r > TLEN_W'(MAX_TOKEN_BYTES)) begin
      t_len = TLEN_W'(MAX_TOKEN_BYTES);
    end else begin
      t_len = tok_len_r;
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_LEN1: h_size = 3'd1;
      MODE_LEN2: h_size = 3'd2;
      MODE_LEN4: h_size = 3'd4;
      MODE_TOKEN: h_size = 3'd4;
    endcase
  end

  assign cur_phase = in_restart ? PH_HEADER : phase_r;
  assign cur_accum = in_restart ? '0 : accum_r;
  assign cur_hc    = in_restart ? '0 : hdr_cnt_r;
  assign cur_left  = in_restart ? '0 : left_r;
  assign cur_fill  = in_restart ? '0 : fill_r;

  assign fill_a  = (cur_fill > t_len) ? t_len : cur_fill;
  assign fill2   = fill_a + TLEN_W'(1);
  assign has_old = (fill2 == t_len + TLEN_W'(1));
  assign oldest  = hist_r[HIST_IDX_W'(t_len - TLEN_W'(1))];
  assign emit_ok = (cur_accum < max_len_r);
  assign acc_sh  = {cur_accum[LEN_W-9:0], in_data_byte};
  assign hc1     = cur_hc + 3'd1;

  always_comb begin
    logic [7:0]            cand;
    logic [HIST_IDX_W-1:0] tidx;
    match = (fill2 >= t_len);
    for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
      cand = (k == 0) ? in_data_byte : hist_r[(k == 0) ? 0 : k - 1];
      tidx = HIST_IDX_W'(t_len - TLEN_W'(1) - TLEN_W'(k));
      if ((TLEN_W'(k) < t_len) && (cand != tok_arr[tidx])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    accum_nxt   = accum_r;
    hdr_cnt_nxt = hdr_cnt_r;
    left_nxt    = left_r;
    fill_nxt    = fill_r;
    q_wr        = '0;
    if (in_fire) begin
      phase_nxt   = cur_phase;
      accum_nxt   = cur_accum;
      hdr_cnt_nxt = cur_hc;
      left_nxt    = cur_left;
      fill_nxt    = cur_fill;
      if (cur_phase != PH_ERROR) begin
        if (mode_r == MODE_TOKEN) begin
          if (match || has_old) begin
            if (has_old && !emit_ok) begin
              q_wr.push               = 1'b1;
              q_wr.data.framing_error = 1'b1;
              phase_nxt               = PH_ERROR;
            end else begin
              if (has_old) begin
                q_wr.push                 = 1'b1;
                q_wr.data.payload_byte    = oldest;
                q_wr.data.last_of_message = match;
              end
              if (match) begin
                fill_nxt  = '0;
                accum_nxt = '0;
              end else begin
                fill_nxt  = t_len;
                accum_nxt = cur_accum + LEN_W'(1);
              end
            end
          end else begin
            fill_nxt = fill2;
          end
        end else if (cur_phase == PH_BODY) begin
          q_wr.push              = 1'b1;
          q_wr.data.payload_byte = in_data_byte;
          if (cur_left <= LEN_W'(1)) begin
            q_wr.data.last_of_message = 1'b1;
            phase_nxt   = PH_HEADER;
            left_nxt    = '0;
            accum_nxt   = '0;
            hdr_cnt_nxt = '0;
          end else begin
            left_nxt = cur_left - LEN_W'(1);
          end
        end else begin
          if (hc1 >= h_size) begin
            hdr_cnt_nxt = '0;
            accum_nxt   = '0;
            if ((acc_sh <= LEN_W'(h_size)) || (acc_sh > max_len_r)) begin
              q_wr.push               = 1'b1;
              q_wr.data.framing_error = 1'b1;
              phase_nxt               = PH_ERROR;
            end else begin
              left_nxt  = acc_sh - LEN_W'(h_size);
              phase_nxt = PH_BODY;
            end
          end else begin
            accum_nxt   = acc_sh;
            hdr_cnt_nxt = hc1;
          end
        end
      end
    end
  end

  assign cfg_clear = cfg_we &&
                     ((cfg_index == CFG_FRAMING_MODE) || (cfg_index == CFG_TOKEN_LEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RST_MODE;
      max_len_r   <= RST_MAX_LEN;
      tok_len_r   <= RST_TOKEN_LEN;
      tok_bytes_r <= RST_TOKEN_BYTES;
      phase_r     <= PH_HEADER;
      accum_r     <= '0;
      hdr_cnt_r   <= '0;
      left_r      <= '0;
      fill_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAMING_MODE: mode_r      <= mode_t'(cfg_wdata[1:0]);
          CFG_MAX_LEN:      max_len_r   <= cfg_wdata[LEN_W-1:0];
          CFG_TOKEN_LEN:    tok_len_r   <= cfg_wdata[TLEN_W-1:0];
          CFG_TOKEN_BYTES:  tok_bytes_r <= cfg_wdata;
        endcase
      end
      if (cfg_clear) begin
        phase_r   <= PH_HEADER;
        accum_r   <= '0;
        hdr_cnt_r <= '0;
        left_r    <= '0;
        fill_r    <= '0;
      end else begin
        phase_r   <= phase_nxt;
        accum_r   <= accum_nxt;
        hdr_cnt_r <= hdr_cnt_nxt;
        left_r    <= left_nxt;
        fill_r    <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hist_r[0] <= in_data_byte;
      for (int k = 1; k < MAX_TOKEN_BYTES; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

endmodule

### rtl/mdf_queue.sv
module mdf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  mdf_pkg::q_wr_t    q_wr,
  input  logic              pop,
  output logic              full,
  output mdf_pkg::q_head_t  head
);
  import mdf_pkg::*;

  result_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.data  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = q_wr.push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(q_wr.push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.data;
    end
  end

endmodule

### rtl/mdf_back.sv
module mdf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mdf_pkg::q_head_t  head,
  output logic              pop,
  mdf_out_if.source         out_ch
);
  import mdf_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign pop       = head.valid && (!valid_r || out_ch.ready);
  assign valid_nxt = pop ? 1'b1 : (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head.data;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.payload_byte    = data_r.payload_byte;
  assign out_ch.last_of_message = data_r.last_of_message;
  assign out_ch.framing_error   = data_r.framing_error;

endmodule

### rtl/message_stream_deframer.sv
// Message deframer for a byte stream. The in_ch channel carries one stream byte
// per transaction together with a restart flag that clears the framing state
// before that byte. The out_ch channel carries body bytes with a last-of-message
// mark, or a single error transaction for a malformed or overlong message, after
// which all bytes are dropped until a restart or a mode or token length write.
// The cfg port writes the framing mode, the maximum length, the delimiter length
// and the delimiter bytes; the user makes writes only while no bytes are in
// flight, and the block itself leaves this to the user. The framing engine takes
// one byte every cycle while in_ch.ready is high and decides its result in the
// cycle it is accepted; results are registered in a four-entry queue and then
// in an output register. Sustained throughput is one byte per cycle while the
// receiver takes results. When the receiver stalls, results collect in the
// queue and in_ch.ready drops only once the queue is full; it is always high
// while the output register is empty. Reset restores the register defaults
// (four-byte length header, maximum length 102400, two-byte delimiter LF CR)
// and empties the queue; no clearing pass is needed, so bytes are accepted once reset ends.
module message_stream_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  mdf_pkg::cfg_idx_t                cfg_index,
  input  logic [mdf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  mdf_in_if.sink                           in_ch,
  mdf_out_if.source                        out_ch
);
  import mdf_pkg::*;

  q_wr_t   q_wr;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;
  logic    in_fire;

  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  mdf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_fire      (in_fire),
    .in_data_byte (in_ch.data_byte),
    .in_restart   (in_ch.restart),
    .q_wr         (q_wr)
  );

  mdf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .head  (q_head)
  );

  mdf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

### rtl/mdf_checker.sv
module mdf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic       out_last,
  input logic       out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable({out_payload_byte, out_last, out_error}))
    else $error("Stalled output transaction changed.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid right after reset.");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> (out_payload_byte == 8'd0) && !out_last)
    else $error("Error transaction carries body data.");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled while the output is empty.");

endmodule

bind message_stream_deframer mdf_checker u_mdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_payload_byte (out_ch.payload_byte),
  .out_last         (out_ch.last_of_message),
  .out_error        (out_ch.framing_error)
);
